// ----- rtl/generational_slot_allocator_defines.svh -----
// ----------------------------------------------------------------------------
// Generational slot allocator assertion macros
// Shared concurrent check forms for the allocator modules.
// ----------------------------------------------------------------------------
`ifndef GENERATIONAL_SLOT_ALLOCATOR_DEFINES_SVH
`define GENERATIONAL_SLOT_ALLOCATOR_DEFINES_SVH

// check on clk_i, off while rst_ni is low
`define GSA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("generational_slot_allocator: check failed");

// check on an explicit clock and active-low reset
`define GSA_ASSERT_CLK(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("generational_slot_allocator: check failed");

`endif

// ----- rtl/gsa_pkg.sv -----
// ----------------------------------------------------------------------------
// gsa_pkg
// Constants, codes and controller/datapath link types of the slot allocator.
// ----------------------------------------------------------------------------
package gsa_pkg;

  localparam int unsigned SLOTS_DEF    = 1024;
  localparam int unsigned GEN_BITS_DEF = 16;

  localparam int unsigned FUNC_W   = 2;
  localparam int unsigned IDX_PW   = 10;
  localparam int unsigned GEN_PW   = 16;
  localparam int unsigned CNT_PW   = 11;
  localparam int unsigned STATUS_W = 2;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_ALLOC   = 2'd0,
    FUNC_FREE_H  = 2'd1,
    FUNC_FREE_S  = 2'd2,
    FUNC_LOOKUP  = 2'd3
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_NO_SLOT = 2'd1,
    ST_STALE   = 2'd2
  } status_e;

  typedef struct packed {
    logic capture;
    logic alloc_pop;
    logic alloc_fresh;
    logic res_no_slot;
    logic res_stale;
    logic slot_latch;
    logic gen_latch;
    logic alloc_write;
    logic lookup_ok;
    logic free_write;
    logic out_load;
  } gsa_cmd_t;

  typedef struct packed {
    func_e func;
    logic  fc_nz;
    logic  hw_lt_cap;
    logic  idx_in_range;
    logic  handle_live;
    logic  out_free;
  } gsa_sts_t;

endpackage

// ----- rtl/gsa_ram.sv -----
// ----------------------------------------------------------------------------
// gsa_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module gsa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/gsa_datapath.sv -----
// ----------------------------------------------------------------------------
// gsa_datapath
// Slot tables, free stack, dense list, counters and result registers.
// ----------------------------------------------------------------------------
`include "generational_slot_allocator_defines.svh"

module gsa_datapath import gsa_pkg::*; #(
  parameter int unsigned SLOTS    = SLOTS_DEF,
  parameter int unsigned GEN_BITS = GEN_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  input  logic [CNT_PW-1:0]   cfg_data_i,
  input  logic [FUNC_W-1:0]   func_i,
  input  logic [IDX_PW-1:0]   slot_index_i,
  input  logic [GEN_PW-1:0]   handle_gen_i,
  input  logic                out_stall_i,
  output logic                out_valid_o,
  output logic [STATUS_W-1:0] status_o,
  output logic [IDX_PW-1:0]   result_index_o,
  output logic [GEN_PW-1:0]   result_gen_o,
  output logic [IDX_PW-1:0]   list_pos_o,
  output logic [CNT_PW-1:0]   live_count_o,
  output logic                retired_o,
  input  gsa_cmd_t            cmd_i,
  output gsa_sts_t            sts_o
);

  localparam int unsigned IW = $clog2(SLOTS);
  localparam int unsigned CW = $clog2(SLOTS + 1);
  localparam int unsigned SW = GEN_BITS + 1;

  func_e               func_q;
  logic [IDX_PW-1:0]   idx_raw_q;
  logic [GEN_BITS-1:0] hgen_q;
  logic [CW-1:0]       cap_q, cap_d;
  logic [CW-1:0]       free_count_q, free_count_d;
  logic [CW-1:0]       high_water_q, high_water_d;
  logic [CW-1:0]       live_total_q, live_total_d;
  logic [IW-1:0]       s_q;
  logic [GEN_BITS-1:0] gen_q;

  status_e             res_status_q;
  logic [IDX_PW-1:0]   res_index_q;
  logic [GEN_PW-1:0]   res_gen_q;
  logic [IDX_PW-1:0]   res_pos_q;
  logic                res_retired_q;

  logic                out_valid_q;
  status_e             out_status_q;
  logic [IDX_PW-1:0]   out_index_q;
  logic [GEN_PW-1:0]   out_gen_q;
  logic [IDX_PW-1:0]   out_pos_q;
  logic [CNT_PW-1:0]   out_live_q;
  logic                out_retired_q;

  logic [IW-1:0]       idx;
  logic [IW-1:0]       pos_new;
  logic [IW-1:0]       last_pos;
  logic [GEN_BITS-1:0] gen_inc;
  logic                wraps;
  logic                push_ok;
  logic [CW-1:0]       cfg_sat;

  logic                st_we;
  logic [IW-1:0]       st_waddr, st_raddr;
  logic [SW-1:0]       st_wdata, st_rdata;
  logic                dn_we;
  logic [IW-1:0]       dn_waddr, dn_wdata, dn_rdata;
  logic                dp_we;
  logic [IW-1:0]       dp_waddr, dp_wdata, dp_rdata;
  logic                sk_we;
  logic [IW-1:0]       sk_rdata;
  logic                move;

  assign idx      = IW'(idx_raw_q);
  assign pos_new  = IW'(live_total_q);
  assign last_pos = IW'(live_total_q - CW'(1));
  assign gen_inc  = gen_q + GEN_BITS'(1);
  assign wraps    = (gen_inc == '0);
  assign push_ok  = !wraps && (32'(free_count_q) < 32'(SLOTS));
  assign move     = cmd_i.free_write && (dp_rdata != last_pos);
  assign cfg_sat  = (32'(cfg_data_i) > 32'(SLOTS)) ? CW'(SLOTS) : CW'(cfg_data_i);

  // slot state table: {alive, generation}
  always_comb begin
    st_we    = cmd_i.alloc_write || cmd_i.free_write;
    st_waddr = cmd_i.alloc_write ? s_q : idx;
    st_wdata = cmd_i.alloc_write ? {1'b1, gen_q} : {1'b0, gen_inc};
    st_raddr = cmd_i.slot_latch ? sk_rdata : idx;
  end

  always_comb begin
    dn_we    = cmd_i.alloc_write || move;
    dn_waddr = cmd_i.alloc_write ? pos_new : dp_rdata;
    dn_wdata = cmd_i.alloc_write ? s_q : dn_rdata;
    dp_we    = cmd_i.alloc_write || move;
    dp_waddr = cmd_i.alloc_write ? s_q : dn_rdata;
    dp_wdata = cmd_i.alloc_write ? pos_new : dp_rdata;
    sk_we    = cmd_i.free_write && push_ok;
  end

  gsa_ram #(.WIDTH(SW), .DEPTH(SLOTS)) u_state_ram (
    .clk_i, .we_i(st_we), .waddr_i(st_waddr), .wdata_i(st_wdata),
    .raddr_i(st_raddr), .rdata_o(st_rdata)
  );

  gsa_ram #(.WIDTH(IW), .DEPTH(SLOTS)) u_dense_ram (
    .clk_i, .we_i(dn_we), .waddr_i(dn_waddr), .wdata_i(dn_wdata),
    .raddr_i(last_pos), .rdata_o(dn_rdata)
  );

  gsa_ram #(.WIDTH(IW), .DEPTH(SLOTS)) u_dpos_ram (
    .clk_i, .we_i(dp_we), .waddr_i(dp_waddr), .wdata_i(dp_wdata),
    .raddr_i(idx), .rdata_o(dp_rdata)
  );

  gsa_ram #(.WIDTH(IW), .DEPTH(SLOTS)) u_stack_ram (
    .clk_i, .we_i(sk_we), .waddr_i(IW'(free_count_q)), .wdata_i(idx),
    .raddr_i(IW'(free_count_q - CW'(1))), .rdata_o(sk_rdata)
  );

  always_comb begin
    cap_d        = cap_q;
    free_count_d = free_count_q;
    high_water_d = high_water_q;
    live_total_d = live_total_q;
    // capacity only grows
    if (cfg_valid_i && (cfg_sat > cap_q)) begin
      cap_d = cfg_sat;
    end
    if (cmd_i.alloc_pop) begin
      free_count_d = free_count_q - CW'(1);
    end
    if (cmd_i.alloc_fresh) begin
      high_water_d = high_water_q + CW'(1);
    end
    if (cmd_i.alloc_write) begin
      live_total_d = live_total_q + CW'(1);
    end
    if (cmd_i.free_write) begin
      live_total_d = live_total_q - CW'(1);
      if (push_ok) begin
        free_count_d = free_count_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q        <= CW'(SLOTS);
      free_count_q <= '0;
      high_water_q <= '0;
      live_total_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      cap_q        <= cap_d;
      free_count_q <= free_count_d;
      high_water_q <= high_water_d;
      live_total_q <= live_total_d;
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      func_q    <= func_e'(func_i);
      idx_raw_q <= slot_index_i;
      hgen_q    <= GEN_BITS'(handle_gen_i);
    end
    if (cmd_i.alloc_fresh) begin
      s_q   <= IW'(high_water_q);
      gen_q <= GEN_BITS'(1);
    end
    if (cmd_i.slot_latch) begin
      s_q <= sk_rdata;
    end
    if (cmd_i.gen_latch) begin
      gen_q <= st_rdata[GEN_BITS-1:0];
    end
    if (cmd_i.res_no_slot || cmd_i.res_stale) begin
      res_status_q  <= cmd_i.res_no_slot ? ST_NO_SLOT : ST_STALE;
      res_index_q   <= cmd_i.res_no_slot ? '0 : idx_raw_q;
      res_gen_q     <= '0;
      res_pos_q     <= '0;
      res_retired_q <= 1'b0;
    end
    if (cmd_i.lookup_ok) begin
      res_status_q  <= ST_OK;
      res_index_q   <= idx_raw_q;
      res_gen_q     <= GEN_PW'(st_rdata[GEN_BITS-1:0]);
      res_pos_q     <= '0;
      res_retired_q <= 1'b0;
    end
    if (cmd_i.alloc_write) begin
      res_status_q  <= ST_OK;
      res_index_q   <= IDX_PW'(s_q);
      res_gen_q     <= GEN_PW'(gen_q);
      res_pos_q     <= IDX_PW'(pos_new);
      res_retired_q <= 1'b0;
    end
    if (cmd_i.free_write) begin
      res_status_q  <= ST_OK;
      res_index_q   <= idx_raw_q;
      res_gen_q     <= '0;
      res_pos_q     <= '0;
      res_retired_q <= wraps;
    end
    if (cmd_i.out_load) begin
      out_status_q  <= res_status_q;
      out_index_q   <= res_index_q;
      out_gen_q     <= res_gen_q;
      out_pos_q     <= res_pos_q;
      out_live_q    <= CNT_PW'(live_total_q);
      out_retired_q <= res_retired_q;
    end
  end

  always_comb begin
    sts_o.func         = func_q;
    sts_o.fc_nz        = (free_count_q != '0);
    sts_o.hw_lt_cap    = (high_water_q < cap_q);
    sts_o.idx_in_range = (32'(idx_raw_q) < 32'(high_water_q));
    sts_o.handle_live  = st_rdata[SW-1] &&
                         ((func_q == FUNC_FREE_S) || (st_rdata[GEN_BITS-1:0] == hgen_q));
    sts_o.out_free     = !out_valid_q || !out_stall_i;
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign result_index_o = out_index_q;
  assign result_gen_o   = out_gen_q;
  assign list_pos_o     = out_pos_q;
  assign live_count_o   = out_live_q;
  assign retired_o      = out_retired_q;

  `GSA_ASSERT(a_hw_le_cap, high_water_q <= cap_q)
  `GSA_ASSERT(a_live_le_hw, live_total_q <= high_water_q)
  `GSA_ASSERT(a_pool_le_hw, (32'(free_count_q) + 32'(live_total_q)) <= 32'(high_water_q))

endmodule

// ----- rtl/gsa_ctrl.sv -----
// ----------------------------------------------------------------------------
// gsa_ctrl
// Operation sequencer: steps each request through table reads and writes.
// ----------------------------------------------------------------------------
`include "generational_slot_allocator_defines.svh"

module gsa_ctrl import gsa_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  output gsa_cmd_t cmd_o,
  input  gsa_sts_t sts_i
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_ISSUE    = 3'd1;
  localparam logic [2:0] S_ALOC_RD  = 3'd2;
  localparam logic [2:0] S_ALOC_GEN = 3'd3;
  localparam logic [2:0] S_ALOC_WR  = 3'd4;
  localparam logic [2:0] S_CHECK    = 3'd5;
  localparam logic [2:0] S_FREE_MV  = 3'd6;
  localparam logic [2:0] S_DONE     = 3'd7;

  logic [2:0] state_q, state_d;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_ISSUE;
        end
      end
      S_ISSUE: begin
        if (sts_i.func == FUNC_ALLOC) begin
          if (sts_i.fc_nz) begin
            cmd_o.alloc_pop = 1'b1;
            state_d         = S_ALOC_RD;
          end else if (sts_i.hw_lt_cap) begin
            cmd_o.alloc_fresh = 1'b1;
            state_d           = S_ALOC_WR;
          end else begin
            cmd_o.res_no_slot = 1'b1;
            state_d           = S_DONE;
          end
        end else if (sts_i.idx_in_range) begin
          state_d = S_CHECK;
        end else begin
          cmd_o.res_stale = 1'b1;
          state_d         = S_DONE;
        end
      end
      S_ALOC_RD: begin
        cmd_o.slot_latch = 1'b1;
        state_d          = S_ALOC_GEN;
      end
      S_ALOC_GEN: begin
        cmd_o.gen_latch = 1'b1;
        state_d         = S_ALOC_WR;
      end
      S_ALOC_WR: begin
        cmd_o.alloc_write = 1'b1;
        state_d           = S_DONE;
      end
      S_CHECK: begin
        cmd_o.gen_latch = 1'b1;
        if (!sts_i.handle_live) begin
          cmd_o.res_stale = 1'b1;
          state_d         = S_DONE;
        end else if (sts_i.func == FUNC_LOOKUP) begin
          cmd_o.lookup_ok = 1'b1;
          state_d         = S_DONE;
        end else begin
          state_d = S_FREE_MV;
        end
      end
      S_FREE_MV: begin
        cmd_o.free_write = 1'b1;
        state_d          = S_DONE;
      end
      S_DONE: begin
        // hold until the output register can take the result
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `GSA_ASSERT(a_accept_issue, in_valid_i && !in_stall_o |=> state_q == S_ISSUE)
  `GSA_ASSERT_CLK(a_load_free, clk_i, rst_ni, cmd_o.out_load |-> sts_i.out_free)

endmodule

// ----- rtl/generational_slot_allocator.sv -----
// ----------------------------------------------------------------------------
// generational_slot_allocator
// Slot map handing out (index, generation) handles with a dense live list.
//
// Input channel (in_valid_i / in_stall_o) carries func_i, slot_index_i and
// handle_gen_i; one request is taken at a time. Output channel
// (out_valid_o / out_stall_i) returns exactly one result per request.
// Steps from transfer in to result valid: out-of-range handle or allocate
// with no slot left: issue, done; fresh allocate: issue, write, done;
// lookup or stale handle: issue, check, done; free: issue, check, move,
// done; allocate from the free stack: issue, stack read, generation read,
// write, done, through the registered-read slot, dense, position and stack
// RAMs. The next request is taken in the cycle after its result is loaded.
// A new request is taken once the previous result sits in the output
// register, so a stalled receiver holds at most one result while the next
// request is worked on; a finished result then waits for the stall to drop.
// The config channel (cfg_valid_i / cfg_ready_o) is always ready and only
// grows capacity; write it while idle.
// Reset empties the map: no slot alive, capacity at full size; a slot first
// handed out gets generation one. No clearing pass is needed.
// ----------------------------------------------------------------------------
module generational_slot_allocator import gsa_pkg::*; #(
  parameter int unsigned SLOTS    = SLOTS_DEF,
  parameter int unsigned GEN_BITS = GEN_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CNT_PW-1:0]   cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [FUNC_W-1:0]   func_i,
  input  logic [IDX_PW-1:0]   slot_index_i,
  input  logic [GEN_PW-1:0]   handle_gen_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [STATUS_W-1:0] status_o,
  output logic [IDX_PW-1:0]   result_index_o,
  output logic [GEN_PW-1:0]   result_gen_o,
  output logic [IDX_PW-1:0]   list_pos_o,
  output logic [CNT_PW-1:0]   live_count_o,
  output logic                retired_o
);

  gsa_cmd_t cmd;
  gsa_sts_t sts;

  assign cfg_ready_o = 1'b1;

  gsa_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .cmd_o(cmd), .sts_i(sts)
  );

  gsa_datapath #(.SLOTS(SLOTS), .GEN_BITS(GEN_BITS)) u_datapath (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_data_i, .func_i, .slot_index_i,
    .handle_gen_i, .out_stall_i, .out_valid_o, .status_o, .result_index_o,
    .result_gen_o, .list_pos_o, .live_count_o, .retired_o,
    .cmd_i(cmd), .sts_o(sts)
  );

endmodule
